// File: sv/finder_pattern_run_scanner_macros.svh
// ----------------------------------------------------------------------------
// Finder pattern run scanner assertion macros
// Concurrent assertion shorthands, clocked on clk_i, held off during reset.
// ----------------------------------------------------------------------------
`ifndef FINDER_PATTERN_RUN_SCANNER_MACROS_SVH
`define FINDER_PATTERN_RUN_SCANNER_MACROS_SVH

// Same-cycle implication
`define FPRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fprs_pkg.sv
// ----------------------------------------------------------------------------
// Finder pattern run scanner package
// Widths, scoring constants and shared types of the run scanner.
// ----------------------------------------------------------------------------
package fprs_pkg;

  // Field widths
  localparam int RUN_BITS   = 12;
  localparam int COL_BITS   = 12;
  localparam int EDGE_BITS  = 3;
  localparam int CEN_BITS   = 14;
  localparam int SIZE_BITS  = 15;
  localparam int SCORE_BITS = 8;
  localparam int PHASE_BITS = 3;

  // Five scored runs; the sum of five widths fits in three extra bits
  localparam int NUM_RUNS = 5;
  localparam int CTR_RUN  = 2;
  localparam int SUM_BITS = RUN_BITS + 3;
  localparam int ABS_BITS = SUM_BITS + 2;
  localparam int CALC_BITS = ((COL_BITS > RUN_BITS) ? COL_BITS : RUN_BITS) + 3;

  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

  // Divide by seven: multiply by a rounded-up reciprocal and shift
  localparam int DIV_SHIFT = SUM_BITS + 3;
  localparam int DIV_BITS  = DIV_SHIFT - 2;
  localparam int PROD_BITS = SUM_BITS + DIV_BITS;
  localparam logic [DIV_BITS-1:0] DIV_MUL = DIV_BITS'(((2 ** DIV_SHIFT) + 6) / 7);
  localparam int ROUND_ADD = 3;

  // Phase codes (count of edges seen)
  localparam logic [PHASE_BITS-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_RESUME = 3'd4;
  localparam logic [PHASE_BITS-1:0] PH_SCORE  = 3'd6;

  // Ratio rule
  localparam int MIN_RUN     = 2;
  localparam int MIN_PATTERN = MIN_RUN * NUM_RUNS;
  localparam int MIN_TOL     = 2;
  localparam int SCORE_BASE  = 20;
  localparam int SCORE_SYM   = 50;
  localparam int SCORE_MOD   = 14;
  localparam int SCORE_CTR   = 42;

  // Result saturation
  localparam int CEN_MIN  = -8192;
  localparam int CEN_MAX  = 4095;
  localparam int SIZE_MAX = 32767;

  localparam logic [SCORE_BITS-1:0] MIN_SCORE_RST = 8'd160;

  // Front to back queue
  localparam int QDEPTH   = 2;
  localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef logic [RUN_BITS-1:0] run_t;

  // One classified pixel: candidate flag and the widths to score
  typedef struct packed {
    logic                        cand;
    logic [COL_BITS-1:0]         column;
    run_t [NUM_RUNS-1:0]         w;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: sv/fprs_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one edge class per pixel.
// ----------------------------------------------------------------------------
interface fprs_pix_if;
  logic                                valid;
  logic                                ready;
  logic signed [fprs_pkg::EDGE_BITS-1:0] edge_class;
  logic [fprs_pkg::COL_BITS-1:0]       column;
  logic                                row_start;

  modport source (output valid, output edge_class, output column, output row_start,
                  input ready);
  modport sink   (input valid, input edge_class, input column, input row_start,
                  output ready);
endinterface

// File: sv/fprs_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one scan result per pixel.
// ----------------------------------------------------------------------------
interface fprs_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic signed [fprs_pkg::CEN_BITS-1:0] centre_column;
  logic [fprs_pkg::SIZE_BITS-1:0]       pattern_size;

  modport source (output valid, output found, output centre_column,
                  output pattern_size, input ready);
  modport sink   (input valid, input found, input centre_column,
                  input pattern_size, output ready);
endinterface

// File: sv/fprs_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the minimum score register.
// ----------------------------------------------------------------------------
interface fprs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fprs_pkg::SCORE_BITS-1:0] min_score;

  modport source (output valid, output min_score, input ready);
  modport sink   (input valid, input min_score, output ready);
endinterface

// File: sv/finder_pattern_run_scanner.sv
// ----------------------------------------------------------------------------
// Finder pattern run scanner
// Counts dark/light run widths along a row of edge classes and reports
// 1:1:3:1:1 finder pattern candidates with their centre column and size.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i  : one beat per pixel (edge_class, column, row_start). row_start
//            clears the run state before that pixel is counted.
//   res_o  : exactly one beat per pixel, in order. found marks a candidate;
//            centre_column and pattern_size are zero when found is low.
//   cfg_i  : writes min_score (reset 160); write only while no pixel is in
//            flight. cfg_i.ready is always high.
// Timing:
//   A pixel accepted on pix_i is pushed into the two-entry queue; the
//   scorer pops it into the sum stage, then come the reciprocal multiply
//   for sum/7, module size and score stages, whose result register
//   drives res_o. Throughput is one pixel per cycle while res_o does not
//   stall; the run tracker updates its run state in the cycle a pixel is
//   accepted.
// Reset clears the run state, the queue and every pipeline valid.
// When res_o stalls, the scorer pipeline holds and the queue fills; pix_i
// ready drops only once the queue is full.
// ----------------------------------------------------------------------------
module finder_pattern_run_scanner (
  input  logic       clk_i,
  input  logic       rst_ni,
  fprs_pix_if.sink   pix_i,
  fprs_cfg_if.sink   cfg_i,
  fprs_res_if.source res_o
);

  `include "finder_pattern_run_scanner_macros.svh"

  logic [fprs_pkg::SCORE_BITS-1:0] min_score_q;
  fprs_pkg::q_stat_t               q_stat;
  fprs_pkg::item_t                 push_item, pop_item;
  logic                            q_push, q_pop;

  // Minimum score register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_score_q <= fprs_pkg::MIN_SCORE_RST;
    end else if (cfg_i.valid) begin
      min_score_q <= cfg_i.min_score;
    end
  end

  fprs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .item_o   (push_item)
  );

  fprs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .item_o (pop_item)
  );

  fprs_score u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .item_i      (pop_item),
    .pop_o       (q_pop),
    .min_score_i (min_score_q),
    .res_o       (res_o)
  );

  // Checks
  `FPRS_ASSERT_NOW(a_found_min_size, res_o.valid && res_o.found, res_o.pattern_size >= fprs_pkg::SIZE_BITS'(fprs_pkg::MIN_PATTERN), "candidate smaller than five minimum runs")
  `FPRS_ASSERT_NOW(a_miss_zero, res_o.valid && !res_o.found, res_o.centre_column == '0 && res_o.pattern_size == '0, "non-candidate result carries nonzero fields")
  `FPRS_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, q_stat.full, "queue lost an item without a pop")

endmodule

// File: sv/fprs_front.sv
// ----------------------------------------------------------------------------
// Run tracker
// Follows the dark/light runs along a row and pushes one item per pixel,
// flagged as a candidate when the sixth run begins.
// ----------------------------------------------------------------------------
module fprs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  fprs_pix_if.sink           pix_i,
  input  fprs_pkg::q_stat_t  q_stat_i,
  output logic               push_o,
  output fprs_pkg::item_t    item_o
);

  // Phase holds 0..5 between beats; 6 only exists within a beat
  logic [fprs_pkg::PHASE_BITS-1:0]            phase_q, phase_d;
  fprs_pkg::run_t [fprs_pkg::NUM_RUNS-1:0]    w_q, w_d;

  logic [fprs_pkg::PHASE_BITS-1:0]            ph, ph_n;
  fprs_pkg::run_t [fprs_pkg::NUM_RUNS-1:0]    wc, w_inc;
  logic                                       neg, pos, cand;

  assign pix_i.ready = !q_stat_i.full;
  assign push_o      = pix_i.valid && pix_i.ready;

  // Edge decode and run update
  always_comb begin
    ph  = pix_i.row_start ? fprs_pkg::PH_IDLE : phase_q;
    wc  = pix_i.row_start ? '0 : w_q;
    neg = pix_i.edge_class[fprs_pkg::EDGE_BITS-1];
    pos = !neg && (pix_i.edge_class != '0);

    ph_n = ph;
    if (ph == fprs_pkg::PH_IDLE) begin
      if (neg) ph_n = ph + fprs_pkg::PHASE_BITS'(1);
    end else if (ph[0]) begin
      if (pos) ph_n = ph + fprs_pkg::PHASE_BITS'(1);
    end else begin
      if (neg) ph_n = ph + fprs_pkg::PHASE_BITS'(1);
    end

    // Saturating width count of the run this pixel falls in
    w_inc = wc;
    for (int i = 0; i < fprs_pkg::NUM_RUNS; i++) begin
      if (ph_n == fprs_pkg::PHASE_BITS'(i + 1) && wc[i] != fprs_pkg::RUN_MAX) begin
        w_inc[i] = wc[i] + fprs_pkg::RUN_BITS'(1);
      end
    end

    cand = (ph_n == fprs_pkg::PH_SCORE);

    // After a score, keep the last three runs; the new sixth run is one wide
    if (cand) begin
      phase_d  = fprs_pkg::PH_RESUME;
      w_d[0]   = w_inc[2];
      w_d[1]   = w_inc[3];
      w_d[2]   = w_inc[4];
      w_d[3]   = fprs_pkg::RUN_BITS'(1);
      w_d[4]   = '0;
    end else begin
      phase_d  = ph_n;
      w_d      = w_inc;
    end

    item_o.cand   = cand;
    item_o.column = pix_i.column;
    item_o.w      = w_inc;
  end

  // Run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fprs_pkg::PH_IDLE;
      w_q     <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      w_q     <= w_d;
    end
  end

endmodule

// File: sv/fprs_queue.sv
// ----------------------------------------------------------------------------
// Item queue
// Short FIFO between the run tracker and the scorer.
// ----------------------------------------------------------------------------
module fprs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fprs_pkg::item_t    item_i,
  input  logic               pop_i,
  output fprs_pkg::q_stat_t  stat_o,
  output fprs_pkg::item_t    item_o
);

  fprs_pkg::item_t                 mem_q [fprs_pkg::QDEPTH];
  logic [fprs_pkg::QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [fprs_pkg::QCNT_BITS-1:0]  cnt_q;
  logic                            do_push, do_pop;

  assign stat_o.full  = (cnt_q == fprs_pkg::QCNT_BITS'(fprs_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == fprs_pkg::QPTR_BITS'(fprs_pkg::QDEPTH - 1)) ? '0
                    : wr_ptr_q + fprs_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == fprs_pkg::QPTR_BITS'(fprs_pkg::QDEPTH - 1)) ? '0
                    : rd_ptr_q + fprs_pkg::QPTR_BITS'(1);
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + fprs_pkg::QCNT_BITS'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - fprs_pkg::QCNT_BITS'(1);
    end
  end

endmodule

// File: sv/fprs_score.sv
// ----------------------------------------------------------------------------
// Ratio scorer
// Four-stage pipeline scoring five run widths against the 1:1:3:1:1 rule.
// ----------------------------------------------------------------------------
module fprs_score (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fprs_pkg::q_stat_t                  q_stat_i,
  input  fprs_pkg::item_t                    item_i,
  output logic                               pop_o,
  input  logic [fprs_pkg::SCORE_BITS-1:0]    min_score_i,
  fprs_res_if.source                         res_o
);

  localparam logic signed [fprs_pkg::CALC_BITS-1:0] CEN_LO =
    fprs_pkg::CALC_BITS'(fprs_pkg::CEN_MIN);
  localparam logic signed [fprs_pkg::CALC_BITS-1:0] CEN_HI =
    fprs_pkg::CALC_BITS'(fprs_pkg::CEN_MAX);

  function automatic logic [fprs_pkg::ABS_BITS-1:0] absdiff(
    logic [fprs_pkg::ABS_BITS-1:0] a, logic [fprs_pkg::ABS_BITS-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Stage handshake
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdy_o;

  assign rdy_o = !vo_q || res_o.ready;
  assign rdy3  = !v3_q || rdy_o;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign pop_o = !q_stat_i.empty && rdy1;

  // Stage 1: sum, shape gate, centre column
  logic                                       p1_cand, p1_gate;
  fprs_pkg::run_t [fprs_pkg::NUM_RUNS-1:0]    p1_w;
  logic [fprs_pkg::SUM_BITS-1:0]              p1_sum, sum1;
  logic signed [fprs_pkg::CEN_BITS-1:0]       p1_cen, cen1;
  logic signed [fprs_pkg::CALC_BITS-1:0]      cen_full;
  logic                                       gate1;

  always_comb begin
    sum1  = '0;
    gate1 = 1'b1;
    for (int i = 0; i < fprs_pkg::NUM_RUNS; i++) begin
      sum1 = sum1 + fprs_pkg::SUM_BITS'(item_i.w[i]);
      if (item_i.w[i] < fprs_pkg::RUN_BITS'(fprs_pkg::MIN_RUN)) gate1 = 1'b0;
      if (i != fprs_pkg::CTR_RUN && item_i.w[fprs_pkg::CTR_RUN] <= item_i.w[i]) begin
        gate1 = 1'b0;
      end
    end
    cen_full = fprs_pkg::CALC_BITS'(item_i.column)
             - fprs_pkg::CALC_BITS'(item_i.w[4])
             - fprs_pkg::CALC_BITS'(item_i.w[3])
             - fprs_pkg::CALC_BITS'(item_i.w[fprs_pkg::CTR_RUN] >> 1);
    if (cen_full < CEN_LO)      cen1 = fprs_pkg::CEN_BITS'(CEN_LO);
    else if (cen_full > CEN_HI) cen1 = fprs_pkg::CEN_BITS'(CEN_HI);
    else                        cen1 = fprs_pkg::CEN_BITS'(cen_full);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      p1_cand <= item_i.cand;
      p1_gate <= gate1;
      p1_w    <= item_i.w;
      p1_sum  <= sum1;
      p1_cen  <= cen1;
    end
  end

  // Stage 2: reciprocal product for round(sum/7)
  logic                                       p2_cand, p2_gate;
  fprs_pkg::run_t [fprs_pkg::NUM_RUNS-1:0]    p2_w;
  logic [fprs_pkg::SUM_BITS-1:0]              p2_sum;
  logic signed [fprs_pkg::CEN_BITS-1:0]       p2_cen;
  logic [fprs_pkg::PROD_BITS-1:0]             p2_prod;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      p2_cand <= p1_cand;
      p2_gate <= p1_gate;
      p2_w    <= p1_w;
      p2_sum  <= p1_sum;
      p2_cen  <= p1_cen;
      p2_prod <= fprs_pkg::PROD_BITS'(p1_sum + fprs_pkg::SUM_BITS'(fprs_pkg::ROUND_ADD))
               * fprs_pkg::PROD_BITS'(fprs_pkg::DIV_MUL);
    end
  end

  // Stage 3: module size and tolerances
  logic                                       p3_cand, p3_gate;
  fprs_pkg::run_t [fprs_pkg::NUM_RUNS-1:0]    p3_w;
  logic [fprs_pkg::SUM_BITS-1:0]              p3_sum;
  logic signed [fprs_pkg::CEN_BITS-1:0]       p3_cen;
  logic [fprs_pkg::SUM_BITS-1:0]              p3_m, p3_v, m3, v3;
  logic [fprs_pkg::ABS_BITS-1:0]              p3_m3, p3_v3;

  always_comb begin
    m3 = fprs_pkg::SUM_BITS'(p2_prod >> fprs_pkg::DIV_SHIFT);
    v3 = m3 >> 1;
    if (v3 < fprs_pkg::SUM_BITS'(fprs_pkg::MIN_TOL)) v3 = fprs_pkg::SUM_BITS'(fprs_pkg::MIN_TOL);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      p3_cand <= p2_cand;
      p3_gate <= p2_gate;
      p3_w    <= p2_w;
      p3_sum  <= p2_sum;
      p3_cen  <= p2_cen;
      p3_m    <= m3;
      p3_v    <= v3;
      p3_m3   <= fprs_pkg::ABS_BITS'(m3) + fprs_pkg::ABS_BITS'({m3, 1'b0});
      p3_v3   <= fprs_pkg::ABS_BITS'(v3) + fprs_pkg::ABS_BITS'({v3, 1'b0});
    end
  end

  // Stage 4: score, threshold and result register
  logic [fprs_pkg::ABS_BITS-1:0]   m_x, v_x;
  logic [fprs_pkg::SCORE_BITS-1:0] score;
  logic                            found4;
  logic [fprs_pkg::SIZE_BITS-1:0]  size4;

  always_comb begin
    m_x   = fprs_pkg::ABS_BITS'(p3_m);
    v_x   = fprs_pkg::ABS_BITS'(p3_v);
    score = fprs_pkg::SCORE_BITS'(fprs_pkg::SCORE_BASE);
    if (absdiff(fprs_pkg::ABS_BITS'(p3_w[0]), fprs_pkg::ABS_BITS'(p3_w[4])) < v_x)
      score = score + fprs_pkg::SCORE_BITS'(fprs_pkg::SCORE_SYM);
    if (absdiff(fprs_pkg::ABS_BITS'(p3_w[1]), fprs_pkg::ABS_BITS'(p3_w[3])) < v_x)
      score = score + fprs_pkg::SCORE_BITS'(fprs_pkg::SCORE_SYM);
    for (int i = 0; i < fprs_pkg::NUM_RUNS; i++) begin
      if (i != fprs_pkg::CTR_RUN && absdiff(m_x, fprs_pkg::ABS_BITS'(p3_w[i])) < v_x)
        score = score + fprs_pkg::SCORE_BITS'(fprs_pkg::SCORE_MOD);
    end
    if (absdiff(p3_m3, fprs_pkg::ABS_BITS'(p3_w[fprs_pkg::CTR_RUN])) < p3_v3)
      score = score + fprs_pkg::SCORE_BITS'(fprs_pkg::SCORE_CTR);

    found4 = p3_cand && p3_gate && (score > min_score_i);
    size4  = (32'(p3_sum) > fprs_pkg::SIZE_MAX) ? fprs_pkg::SIZE_BITS'(fprs_pkg::SIZE_MAX)
           : fprs_pkg::SIZE_BITS'(p3_sum);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      res_o.found         <= found4;
      res_o.centre_column <= found4 ? p3_cen : '0;
      res_o.pattern_size  <= found4 ? size4 : '0;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q <= pop_o;
      if (rdy2)  v2_q <= v1_q;
      if (rdy3)  v3_q <= v2_q;
      if (rdy_o) vo_q <= v3_q;
    end
  end

  assign res_o.valid = vo_q;

endmodule
